[hw/rtl/derb_pkg.sv]
// package for the double-ended ring buffer: sizes, op and status codes,
// and the result bookkeeping struct; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package derb_pkg;

    localparam int DEPTH  = 64;
    localparam int DATA_W = 8;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = PTR_W + 1;
    localparam int OP_W   = 3;
    localparam int IDX_W  = 6;
    localparam int STAT_W = 2;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_READ_IDX   = 3'd4,
        OP_CLEAR      = 3'd5
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_POP_EMPTY = 2'd2
    } status_t;

    // everything about a result except the memory read data
    typedef struct packed {
        logic             rd_ok;
        logic [CNT_W-1:0] count;
        logic             is_full;
        logic             is_empty;
        logic             overwrote;
        status_t          status;
    } rsp_info_t;

endpackage

`default_nettype wire

[hw/rtl/derb_if.sv]
// channel interfaces of the double-ended ring buffer: request, response, config
// depends on derb_pkg
`timescale 1ns / 1ps
`default_nettype none

interface derb_req_if;
    logic                         valid;
    logic                         ready;
    logic [derb_pkg::OP_W-1:0]    op;
    logic [derb_pkg::DATA_W-1:0]  data;
    logic [derb_pkg::IDX_W-1:0]   index;

    modport source (output valid, op, data, index, input ready);
    modport sink (input valid, op, data, index, output ready);
endinterface

interface derb_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [derb_pkg::DATA_W-1:0]  read_data;
    logic [derb_pkg::CNT_W-1:0]   count;
    logic                         is_full;
    logic                         is_empty;
    logic                         overwrote;
    logic [derb_pkg::STAT_W-1:0]  status;

    modport source (output valid, read_data, count, is_full, is_empty, overwrote, status,
                    input ready);
    modport sink (input valid, read_data, count, is_full, is_empty, overwrote, status,
                  output ready);
endinterface

interface derb_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [derb_pkg::CNT_W-1:0]   data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/derb_store.sv]
// element store of the double-ended ring buffer: single-port synchronous ram,
// one access per cycle, registered read data; depends on derb_pkg
`timescale 1ns / 1ps
`default_nettype none

module derb_store (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic                        re,
    input  wire logic [derb_pkg::PTR_W-1:0]  addr,
    input  wire logic [derb_pkg::DATA_W-1:0] wdata,
    output logic      [derb_pkg::DATA_W-1:0] rdata
);
    import derb_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hw/rtl/double_ended_ring_buffer.sv]
// double-ended ring buffer with overwrite on full, top level
// depends on derb_pkg, derb_if and derb_store
//
// usage:
//   req carries one operation per beat (op, data, index); rsp returns exactly
//   one beat per request with read data, count, full/empty, overwrite flag and
//   status. cfg sets the capacity (clamped to 1..DEPTH) and empties the buffer;
//   write it only while no request is in flight. cfg.ready drops only in a
//   cycle that accepts a request.
// timing:
//   pointers and count are updated in the accept cycle and the element ram is
//   read or written at that same edge; the ram's registered read data is
//   joined with the result saved in the read stage into the output register,
//   which drives rsp.valid. one request per cycle is sustained while rsp.ready
//   stays high.
// reset:
//   count, pointers and valids clear, capacity returns to DEPTH. ram contents
//   are left as they are; only slots that hold elements are ever read.
// backpressure:
//   while rsp is stalled, one result waits in the output register and one more
//   in the read stage; req.ready then drops until the output drains.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_ring_buffer (
    input  wire logic  clk,
    input  wire logic  rst_n,
    derb_cfg_if.sink   cfg,
    derb_req_if.sink   req,
    derb_rsp_if.source rsp
);
    import derb_pkg::*;

    logic [CNT_W-1:0]  cap_reg,   cap_next;
    logic [PTR_W-1:0]  head_reg,  head_next;
    logic [PTR_W-1:0]  tail_reg,  tail_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;

    logic              p1_valid_reg;
    rsp_info_t         p1_info_reg;
    logic              out_valid_reg;
    rsp_info_t         out_info_reg;
    logic [DATA_W-1:0] out_data_reg;

    logic              p1_move;
    logic              req_fire;
    logic              cfg_fire;
    rsp_info_t         info;
    logic              mem_we;
    logic              mem_re;
    logic [PTR_W-1:0]  mem_addr;
    logic [DATA_W-1:0] mem_rdata;
    logic              full;
    logic [CNT_W-1:0]  cap_in;
    logic [CNT_W-1:0]  idx_sum;
    logic [CNT_W-1:0]  idx_wrap;
    logic [PTR_W-1:0]  head_prev;
    logic [PTR_W-1:0]  tail_prev;

    function automatic logic [PTR_W-1:0] pos_next(input logic [PTR_W-1:0] p,
                                                  input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] inc;
        inc = {1'b0, p} + CNT_W'(1);
        return (inc >= cap) ? '0 : inc[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] pos_prev(input logic [PTR_W-1:0] p,
                                                  input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] dec;
        dec = cap - CNT_W'(1);
        return (p == '0) ? dec[PTR_W-1:0] : p - PTR_W'(1);
    endfunction

    assign p1_move   = !out_valid_reg || rsp.ready;
    assign req.ready = !p1_valid_reg || p1_move;
    assign req_fire  = req.valid && req.ready;

    // a request beat takes the cycle, the cfg beat waits
    assign cfg.ready = !req_fire;
    assign cfg_fire  = cfg.valid && cfg.ready;

    assign full      = (cnt_reg >= cap_reg);
    assign head_prev = pos_prev(head_reg, cap_reg);
    assign tail_prev = pos_prev(tail_reg, cap_reg);
    assign idx_sum   = {1'b0, head_reg} + CNT_W'(req.index);
    assign idx_wrap  = (idx_sum >= cap_reg) ? idx_sum - cap_reg : idx_sum;

    // capacity write clamp
    always_comb
    begin
        cap_in = cfg.data;
        if (cap_in == '0)
        begin
            cap_in = CNT_W'(1);
        end
        else if (cap_in > CAP_RESET)
        begin
            cap_in = CAP_RESET;
        end
    end

    always_comb
    begin
        cap_next       = cap_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cnt_next       = cnt_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = tail_reg;
        info.rd_ok     = 1'b0;
        info.overwrote = 1'b0;
        info.status    = ST_OK;

        case (op_t'(req.op))
            OP_PUSH_BACK:
            begin
                mem_we    = 1'b1;
                mem_addr  = tail_reg;
                tail_next = pos_next(tail_reg, cap_reg);
                if (full)
                begin
                    head_next      = pos_next(head_reg, cap_reg);
                    info.overwrote = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            OP_PUSH_FRONT:
            begin
                mem_we    = 1'b1;
                mem_addr  = head_prev;
                head_next = head_prev;
                if (full)
                begin
                    tail_next      = tail_prev;
                    info.overwrote = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            OP_POP_BACK, OP_POP_FRONT:
            begin
                if (cnt_reg == '0)
                begin
                    info.status = ST_POP_EMPTY;
                end
                else
                begin
                    mem_re     = 1'b1;
                    info.rd_ok = 1'b1;
                    cnt_next   = cnt_reg - CNT_W'(1);
                    if (op_t'(req.op) == OP_POP_BACK)
                    begin
                        mem_addr  = tail_prev;
                        tail_next = tail_prev;
                    end
                    else
                    begin
                        mem_addr  = head_reg;
                        head_next = pos_next(head_reg, cap_reg);
                    end
                    // last element gone: pointers go home
                    if (cnt_reg == CNT_W'(1))
                    begin
                        head_next = '0;
                        tail_next = '0;
                    end
                end
            end
            OP_READ_IDX:
            begin
                if (CNT_W'(req.index) >= cnt_reg)
                begin
                    info.status = ST_RANGE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    info.rd_ok = 1'b1;
                    mem_addr   = idx_wrap[PTR_W-1:0];
                end
            end
            OP_CLEAR:
            begin
                head_next = '0;
                tail_next = '0;
                cnt_next  = '0;
            end
            default:
            begin
            end
        endcase

        info.count    = cnt_next;
        info.is_full  = (cnt_next == cap_reg);
        info.is_empty = (cnt_next == '0);

        if (!req_fire)
        begin
            head_next = head_reg;
            tail_next = tail_reg;
            cnt_next  = cnt_reg;
            mem_we    = 1'b0;
            mem_re    = 1'b0;
        end

        if (cfg_fire)
        begin
            cap_next  = cap_in;
            head_next = '0;
            tail_next = '0;
            cnt_next  = '0;
        end
    end

    derb_store u_store (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (req.data),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            head_reg      <= '0;
            tail_reg      <= '0;
            cnt_reg       <= '0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg  <= cap_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
            if (req.ready)
            begin
                p1_valid_reg <= req_fire;
            end
            if (p1_move)
            begin
                out_valid_reg <= p1_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            p1_info_reg <= info;
        end
        if (p1_move && p1_valid_reg)
        begin
            out_info_reg <= p1_info_reg;
            out_data_reg <= p1_info_reg.rd_ok ? mem_rdata : '0;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_data_reg;
    assign rsp.count     = out_info_reg.count;
    assign rsp.is_full   = out_info_reg.is_full;
    assign rsp.is_empty  = out_info_reg.is_empty;
    assign rsp.overwrote = out_info_reg.overwrote;
    assign rsp.status    = out_info_reg.status;

endmodule

`default_nettype wire
